@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low reset disable
`define PCRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define PCRC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ rtl/core/pcrc_pkg.sv @@
// shared types and constants for the paged cache with refcounted slots
// no dependencies
`timescale 1ns / 1ps

package pcrc_pkg;

    localparam int NUM_PAGES_DEF = 64;
    localparam int FILL_W        = 16;
    localparam int TOTAL_W       = 48;
    localparam logic [FILL_W-1:0]  TPP_RESET = 16'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_FORK     = 2'd1,
        CMD_ROLLBACK = 2'd2,
        CMD_RELEASE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_BAD_STATE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDP  = 5'b00010,
        S_EXEC = 5'b00100,
        S_WR2  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

endpackage

@@ rtl/core/pcrc_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pcrc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/pcrc_ffz.sv @@
// lowest clear bit finder for page and slot allocation
// no dependencies
`timescale 1ns / 1ps

module pcrc_ffz #(
    parameter int N = 64
) (
    input  logic [N-1:0]         vec,
    output logic [$clog2(N)-1:0] idx
);

    localparam int IW = $clog2(N);

    always_comb
    begin
        idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!vec[i])
            begin
                idx = IW'(i);
            end
        end
    end

endmodule

@@ rtl/core/paged_cache_refcount_cow.sv @@
// an accepted item passes S_RDP, S_EXEC, S_WR2 (copy-on-write detach only) and S_FIN;
// the page-table read feeds the dependent slot read-modify-write; no new item is taken
// until the last leaves S_FIN, and a result not yet taken holds the next item
// reset: asynchronous active low; clears all valid bits, shared count, total, handshake;
// free counts go to NUM_PAGES, tokens_per_page to 16; memory contents need no clearing
// depends on pcrc_pkg, pcrc_ram, pcrc_ffz
`timescale 1ns / 1ps

module paged_cache_refcount_cow
    import pcrc_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [FILL_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [5:0]          page_id,
    input  logic                new_page,
    input  logic [15:0]         tok_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [5:0]          result_page,
    output logic [15:0]         page_fill,
    output logic [6:0]          free_page_count,
    output logic [6:0]          free_slot_count,
    output logic [6:0]          shared_slot_count,
    output logic [47:0]         token_total
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int CW  = $clog2(NUM_PAGES + 1);
    localparam int SDW = FILL_W + CW;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [5:0]  pid_reg, pid_next;
    logic        new_reg, new_next;
    logic [15:0] n_reg, n_next;
    logic        ok_reg, ok_next;
    logic        wr2_reg, wr2_next;
    logic [PW-1:0] slot_reg, slot_next;
    logic [NUM_PAGES-1:0] pv_reg, pv_next, sv_reg, sv_next;
    logic [CW-1:0] fp_reg, fp_next, fs_reg, fs_next, sh_reg, sh_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [FILL_W-1:0]  tpp_reg, tpp_next;
    status_t     res_status_reg, res_status_next;
    logic [5:0]  res_page_reg, res_page_next;
    logic [15:0] res_fill_reg, res_fill_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [5:0]  rpage_reg, rpage_next;
    logic [15:0] fill_reg, fill_next;
    logic [6:0]  ofp_reg, ofp_next, ofs_reg, ofs_next, osh_reg, osh_next;
    logic [47:0] ototal_reg, ototal_next;

    logic          accept;
    logic [PW-1:0] pidx;
    logic [PW-1:0] free_page_idx, free_slot_idx;
    logic [PW-1:0] page_rdata;
    logic [SDW-1:0] slot_rdata;
    logic [FILL_W-1:0] fill_rd;
    logic [CW-1:0]     refs_rd;
    logic          pg_we, sl_we;
    logic [PW-1:0] pg_waddr, pg_wdata, sl_waddr;
    logic [SDW-1:0] sl_wdata;

    logic [16:0] sum17;
    logic        ovf, argbad, under, bad_mod, is_app, shared_det;
    logic [TOTAL_W:0]   tot_sum;
    logic [TOTAL_W-1:0] tot_add, tot_sub;
    logic [FILL_W-1:0]  newfill, kept_fill, fill_ok;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign pidx     = PW'(pid_reg);
    assign fill_rd  = slot_rdata[SDW-1:CW];
    assign refs_rd  = slot_rdata[CW-1:0];

    pcrc_ram #(.DEPTH(NUM_PAGES), .WIDTH(PW)) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .re    (accept),
        .raddr (PW'(page_id)),
        .rdata (page_rdata)
    );

    pcrc_ram #(.DEPTH(NUM_PAGES), .WIDTH(SDW)) u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .re    (state_reg == S_RDP),
        .raddr (page_rdata),
        .rdata (slot_rdata)
    );

    pcrc_ffz #(.N(NUM_PAGES)) u_page_ffz (.vec(pv_reg), .idx(free_page_idx));
    pcrc_ffz #(.N(NUM_PAGES)) u_slot_ffz (.vec(sv_reg), .idx(free_slot_idx));

    always_comb
    begin
        is_app     = (cmd_reg == CMD_APPEND);
        sum17      = {1'b0, fill_rd} + {1'b0, n_reg};
        ovf        = sum17 > {1'b0, tpp_reg};
        argbad     = (n_reg == '0) || (n_reg > tpp_reg);
        under      = n_reg > fill_rd;
        bad_mod    = is_app ? ovf : under;
        shared_det = refs_rd > CW'(1);
        tot_sum    = {1'b0, total_reg} + (TOTAL_W + 1)'(n_reg);
        tot_add    = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
        tot_sub    = (total_reg >= TOTAL_W'(n_reg)) ? total_reg - TOTAL_W'(n_reg) : total_reg;
        newfill    = is_app ? sum17[15:0] : fill_rd - n_reg;
        kept_fill  = bad_mod ? fill_rd : newfill;
        fill_ok    = ok_reg ? fill_rd : '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        new_next        = new_reg;
        n_next          = n_reg;
        ok_next         = ok_reg;
        wr2_next        = wr2_reg;
        slot_next       = slot_reg;
        pv_next         = pv_reg;
        sv_next         = sv_reg;
        fp_next         = fp_reg;
        fs_next         = fs_reg;
        sh_next         = sh_reg;
        total_next      = total_reg;
        tpp_next        = cfg_we ? cfg_wdata : tpp_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_fill_next   = res_fill_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        rpage_next      = rpage_reg;
        fill_next       = fill_reg;
        ofp_next        = ofp_reg;
        ofs_next        = ofs_reg;
        osh_next        = osh_reg;
        ototal_next     = ototal_reg;
        pg_we           = 1'b0;
        pg_waddr        = pidx;
        pg_wdata        = slot_reg;
        sl_we           = 1'b0;
        sl_waddr        = slot_reg;
        sl_wdata        = slot_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(cmd);
                    pid_next   = page_id;
                    new_next   = new_page;
                    n_next     = tok_in;
                    ok_next    = (32'(page_id) < 32'(NUM_PAGES)) && pv_reg[PW'(page_id)];
                    state_next = S_RDP;
                end
            end
            S_RDP:
            begin
                slot_next  = page_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                wr2_next        = 1'b0;
                res_page_next   = pid_reg;
                res_status_next = ST_OK;
                res_fill_next   = fill_ok;
                state_next      = S_FIN;
                case (cmd_reg)
                    CMD_APPEND, CMD_ROLLBACK:
                    begin
                        if (is_app && argbad)
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                        else if (is_app && new_reg)
                        begin
                            if (fs_reg == '0 || fp_reg == '0)
                            begin
                                res_status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                sl_we    = 1'b1;
                                sl_waddr = free_slot_idx;
                                sl_wdata = {n_reg, CW'(1)};
                                pg_we    = 1'b1;
                                pg_waddr = free_page_idx;
                                pg_wdata = free_slot_idx;
                                pv_next[free_page_idx] = 1'b1;
                                sv_next[free_slot_idx] = 1'b1;
                                fp_next       = fp_reg - CW'(1);
                                fs_next       = fs_reg - CW'(1);
                                total_next    = tot_add;
                                res_page_next = 6'(free_page_idx);
                                res_fill_next = n_reg;
                            end
                        end
                        else if (!ok_reg)
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                        else if (shared_det && fs_reg == '0)
                        begin
                            res_status_next = ST_NO_ROOM;
                        end
                        else
                        begin
                            res_fill_next = kept_fill;
                            if (bad_mod)
                            begin
                                res_status_next = is_app ? ST_NO_ROOM : ST_BAD_ARG;
                            end
                            else
                            begin
                                total_next = is_app ? tot_add : tot_sub;
                            end
                            if (shared_det)
                            begin
                                sl_we    = 1'b1;
                                sl_waddr = free_slot_idx;
                                sl_wdata = {kept_fill, CW'(1)};
                                pg_we    = 1'b1;
                                pg_wdata = free_slot_idx;
                                sv_next[free_slot_idx] = 1'b1;
                                fs_next = fs_reg - CW'(1);
                                if (refs_rd == CW'(2))
                                begin
                                    sh_next = sh_reg - CW'(1);
                                end
                                wr2_next   = 1'b1;
                                state_next = S_WR2;
                            end
                            else if (!bad_mod)
                            begin
                                sl_we    = 1'b1;
                                sl_wdata = {newfill, refs_rd};
                            end
                        end
                    end
                    CMD_FORK:
                    begin
                        if (!ok_reg)
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                        else if (fp_reg == '0)
                        begin
                            res_status_next = ST_NO_ROOM;
                        end
                        else
                        begin
                            pg_we    = 1'b1;
                            pg_waddr = free_page_idx;
                            pv_next[free_page_idx] = 1'b1;
                            fp_next  = fp_reg - CW'(1);
                            sl_we    = 1'b1;
                            sl_wdata = {fill_rd, refs_rd + CW'(1)};
                            if (refs_rd == CW'(1))
                            begin
                                sh_next = sh_reg + CW'(1);
                            end
                            res_page_next = 6'(free_page_idx);
                        end
                    end
                    default:
                    begin
                        if (!ok_reg)
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                        else if (refs_rd == '0)
                        begin
                            res_status_next = ST_BAD_STATE;
                        end
                        else
                        begin
                            if (refs_rd == CW'(2))
                            begin
                                sh_next = sh_reg - CW'(1);
                            end
                            if (refs_rd == CW'(1))
                            begin
                                sv_next[slot_reg] = 1'b0;
                                fs_next = fs_reg + CW'(1);
                            end
                            else
                            begin
                                sl_we    = 1'b1;
                                sl_wdata = {fill_rd, refs_rd - CW'(1)};
                            end
                            pv_next[pidx] = 1'b0;
                            fp_next       = fp_reg + CW'(1);
                            res_fill_next = '0;
                        end
                    end
                endcase
            end
            S_WR2:
            begin
                // old shared slot loses the detached reference
                sl_we      = wr2_reg;
                sl_wdata   = {fill_rd, refs_rd - CW'(1)};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    rpage_next     = res_page_reg;
                    fill_next      = res_fill_reg;
                    ofp_next       = 7'(fp_reg);
                    ofs_next       = 7'(fs_reg);
                    osh_next       = 7'(sh_reg);
                    ototal_next    = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= '0;
            sv_reg        <= '0;
            fp_reg        <= CW'(NUM_PAGES);
            fs_reg        <= CW'(NUM_PAGES);
            sh_reg        <= '0;
            total_reg     <= '0;
            tpp_reg       <= TPP_RESET;
            out_valid_reg <= 1'b0;
            wr2_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            sv_reg        <= sv_next;
            fp_reg        <= fp_next;
            fs_reg        <= fs_next;
            sh_reg        <= sh_next;
            total_reg     <= total_next;
            tpp_reg       <= tpp_next;
            out_valid_reg <= out_valid_next;
            wr2_reg       <= wr2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pid_reg        <= pid_next;
        new_reg        <= new_next;
        n_reg          <= n_next;
        ok_reg         <= ok_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_fill_reg   <= res_fill_next;
        status_reg     <= status_next;
        rpage_reg      <= rpage_next;
        fill_reg       <= fill_next;
        ofp_reg        <= ofp_next;
        ofs_reg        <= ofs_next;
        osh_reg        <= osh_next;
        ototal_reg     <= ototal_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign result_page       = rpage_reg;
    assign page_fill         = fill_reg;
    assign free_page_count   = ofp_reg;
    assign free_slot_count   = ofs_reg;
    assign shared_slot_count = osh_reg;
    assign token_total       = ototal_reg;

endmodule

@@ rtl/core/pcrc_checker.sv @@
// port-level checker for paged_cache_refcount_cow, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrc_checker #(
    parameter int NUM_PAGES = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [6:0]  free_page_count,
    input logic [6:0]  free_slot_count,
    input logic [6:0]  shared_slot_count,
    input logic [47:0] token_total
);

    logic [7:0] slot_room;
    logic [7:0] pg_sh_sum;

    assign slot_room = {1'b0, free_slot_count};
    assign pg_sh_sum = {1'b0, free_page_count} + {1'b0, shared_slot_count};

    // one item in flight at a time
    `PCRC_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

    // every used slot has a page, every shared slot at least two
    `PCRC_ASSERT(a_count_relation, clk, rst_n, out_valid |-> ((NUM_PAGES > 64) || (slot_room >= pg_sh_sum)))

    // a stalled result stays valid with its status and token total held
    `PCRC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(token_total)))

    // no result leaves reset
    `PCRC_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid || rst_n)

endmodule

bind paged_cache_refcount_cow pcrc_checker #(.NUM_PAGES(NUM_PAGES)) u_pcrc_checker (.*);

@@ tb/tb_paged_cache_refcount_cow.sv @@
// testbench for paged_cache_refcount_cow: directed and random commands against an
// in-bench model of the page table, refcounted slots, counters and token total
// depends on pcrc_pkg and the rtl of paged_cache_refcount_cow
`timescale 1ns / 1ps

module tb_paged_cache_refcount_cow
    import pcrc_pkg::*;
();

    localparam int NPG = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        status_t     status;
        logic [5:0]  result_page;
        logic [15:0] page_fill;
        logic [6:0]  free_page_count;
        logic [6:0]  free_slot_count;
        logic [6:0]  shared_slot_count;
        logic [47:0] token_total;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [5:0]  page_id;
    logic        new_page;
    logic [15:0] tok_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  result_page;
    logic [15:0] page_fill;
    logic [6:0]  free_page_count;
    logic [6:0]  free_slot_count;
    logic [6:0]  shared_slot_count;
    logic [47:0] token_total;

    paged_cache_refcount_cow dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .page_id(page_id),
        .new_page(new_page), .tok_in(tok_in), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .result_page(result_page),
        .page_fill(page_fill), .free_page_count(free_page_count),
        .free_slot_count(free_slot_count), .shared_slot_count(shared_slot_count),
        .token_total(token_total)
    );

    // model state
    bit          pg_live [NPG];
    int          pg_slot [NPG];
    bit          sl_live [NPG];
    int          sl_fill [NPG];
    int          sl_refs [NPG];
    int          pages_avail;
    int          free_slots;
    int          shared_cnt;
    logic [47:0] tok_total;
    int          tpp;

    cache_result_t expected_results[$];
    bit  failed;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lowest_free_slot();
        for (int i = 0; i < NPG; i++)
            if (!sl_live[i]) return i;
        return -1;
    endfunction

    function automatic int lowest_free_page();
        for (int i = 0; i < NPG; i++)
            if (!pg_live[i]) return i;
        return -1;
    endfunction

    function automatic int grab_slot(int fill);
        int s;
        if (free_slots == 0) return -1;
        s = lowest_free_slot();
        if (s < 0) return -1;
        sl_live[s] = 1;
        sl_fill[s] = fill;
        sl_refs[s] = 1;
        free_slots--;
        return s;
    endfunction

    function automatic int grab_page(int s);
        int p;
        if (pages_avail == 0) return -1;
        p = lowest_free_page();
        if (p < 0) return -1;
        pg_live[p] = 1;
        pg_slot[p] = s;
        pages_avail--;
        return p;
    endfunction

    function automatic bit page_usable(int p);
        return pg_live[p] && sl_live[pg_slot[p]];
    endfunction

    function automatic status_t unshare(int p);
        int old;
        int fresh;
        old = pg_slot[p];
        if (sl_refs[old] <= 1) return ST_OK;
        fresh = grab_slot(sl_fill[old]);
        if (fresh < 0) return ST_NO_ROOM;
        if (sl_refs[old] == 2) shared_cnt--;
        sl_refs[old]--;
        pg_slot[p] = fresh;
        return ST_OK;
    endfunction

    function automatic cache_result_t predict_command(cmd_t c, int p, bit fresh, int n);
        cache_result_t r;
        status_t st;
        int s;
        int np;
        logic [48:0] sum;
        st = ST_OK;
        case (c)
            CMD_APPEND:
            begin
                if (n == 0 || n > tpp) st = ST_BAD_ARG;
                else
                begin
                    if (fresh)
                    begin
                        s = grab_slot(0);
                        if (s < 0) st = ST_NO_ROOM;
                        else
                        begin
                            np = grab_page(s);
                            if (np < 0)
                            begin
                                sl_live[s] = 0;
                                sl_fill[s] = 0;
                                sl_refs[s] = 0;
                                free_slots++;
                                st = ST_NO_ROOM;
                            end
                            else p = np;
                        end
                    end
                    if (st == ST_OK && !page_usable(p)) st = ST_BAD_ARG;
                    if (st == ST_OK) st = unshare(p);
                    if (st == ST_OK)
                    begin
                        s = pg_slot[p];
                        if (sl_fill[s] + n > tpp) st = ST_NO_ROOM;
                        else
                        begin
                            sl_fill[s] += n;
                            sum = {1'b0, tok_total} + 49'(n);
                            tok_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[47:0];
                        end
                    end
                end
            end
            CMD_FORK:
            begin
                if (!page_usable(p)) st = ST_BAD_ARG;
                else
                begin
                    s = pg_slot[p];
                    np = grab_page(s);
                    if (np < 0) st = ST_NO_ROOM;
                    else
                    begin
                        sl_refs[s]++;
                        if (sl_refs[s] == 2) shared_cnt++;
                        p = np;
                    end
                end
            end
            CMD_ROLLBACK:
            begin
                if (!page_usable(p)) st = ST_BAD_ARG;
                else
                begin
                    st = unshare(p);
                    if (st == ST_OK)
                    begin
                        s = pg_slot[p];
                        if (n > sl_fill[s]) st = ST_BAD_ARG;
                        else
                        begin
                            sl_fill[s] -= n;
                            if (tok_total >= 48'(n)) tok_total -= 48'(n);
                        end
                    end
                end
            end
            default:
            begin
                if (!page_usable(p)) st = ST_BAD_ARG;
                else
                begin
                    s = pg_slot[p];
                    if (sl_refs[s] == 0) st = ST_BAD_STATE;
                    else
                    begin
                        if (sl_refs[s] == 2) shared_cnt--;
                        sl_refs[s]--;
                        if (sl_refs[s] == 0)
                        begin
                            sl_live[s] = 0;
                            sl_fill[s] = 0;
                            free_slots++;
                        end
                        pg_live[p] = 0;
                        pg_slot[p] = 0;
                        pages_avail++;
                    end
                end
            end
        endcase
        r.status = st;
        r.result_page = p[5:0];
        r.page_fill = page_usable(p) ? sl_fill[pg_slot[p]][15:0] : 16'd0;
        r.free_page_count = pages_avail[6:0];
        r.free_slot_count = free_slots[6:0];
        r.shared_slot_count = shared_cnt[6:0];
        r.token_total = tok_total;
        return r;
    endfunction

    task automatic send_command(cmd_t c, int p, bit fresh, int n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        page_id <= p[5:0];
        new_page <= fresh;
        tok_in <= n[15:0];
        expected_results.push_back(predict_command(c, p, fresh, n));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_tokens_per_page(int v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v[15:0];
        tpp = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string fname, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s exp %0d got %0d", $time, fname, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // random page: mostly live ones
    function automatic int pick_page();
        int p;
        for (int k = 0; k < 4; k++)
        begin
            p = $urandom_range(NPG - 1);
            if (pg_live[p]) return p;
        end
        return $urandom_range(NPG - 1);
    endfunction

    task automatic test_directed();
        send_command(CMD_ROLLBACK, 63, 1'b1, 16'hffff);
        send_command(CMD_RELEASE, 0, 1'b0, 0);
        send_command(CMD_FORK, 5, 1'b0, 0);
        send_command(CMD_APPEND, 0, 1'b1, 0);
        send_command(CMD_APPEND, 0, 1'b1, 17);
        send_command(CMD_APPEND, 63, 1'b1, 16);
        send_command(CMD_APPEND, 0, 1'b0, 1);
        send_command(CMD_APPEND, 0, 1'b1, 10);
        send_command(CMD_FORK, 1, 1'b0, 0);
        send_command(CMD_APPEND, 2, 1'b0, 3);
        send_command(CMD_ROLLBACK, 1, 1'b0, 11);
        send_command(CMD_FORK, 1, 1'b0, 0);
        send_command(CMD_ROLLBACK, 3, 1'b0, 4);
        send_command(CMD_APPEND, 1, 1'b0, 6);
        send_command(CMD_APPEND, 1, 1'b0, 1);
        send_command(CMD_RELEASE, 1, 1'b0, 0);
        send_command(CMD_RELEASE, 3, 1'b0, 0);
        send_command(CMD_RELEASE, 1, 1'b0, 0);
        send_command(CMD_ROLLBACK, 2, 1'b0, 13);
    endtask

    task automatic test_exhaustion();
        for (int i = 0; i < 66; i++)
            send_command(CMD_APPEND, 0, 1'b1, 1 + $urandom_range(15));
        send_command(CMD_FORK, 0, 1'b0, 0);
        for (int i = 0; i < 64; i++)
            send_command(CMD_RELEASE, i, 1'b0, 0);
        // fill all pages via fork onto one shared slot, then detach two of them
        send_command(CMD_APPEND, 0, 1'b1, 4);
        for (int i = 0; i < 63; i++)
            send_command(CMD_FORK, 0, 1'b0, 0);
        send_command(CMD_APPEND, 5, 1'b0, 1);
        send_command(CMD_ROLLBACK, 6, 1'b0, 1);
        for (int i = 0; i < 64; i++)
            send_command(CMD_RELEASE, i, 1'b0, 0);
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                send_command(CMD_APPEND, pick_page(), 1'($urandom_range(1)),
                             ($urandom_range(9) == 0) ? $urandom_range(16'hffff)
                                                      : $urandom_range(tpp > 0 ? tpp : 1));
            else if (r < 50)
                send_command(CMD_FORK, pick_page(), 1'($urandom_range(1)),
                             $urandom_range(16'hffff));
            else if (r < 72)
                send_command(CMD_ROLLBACK, pick_page(), 1'($urandom_range(1)),
                             ($urandom_range(9) == 0) ? $urandom_range(16'hffff)
                                                      : $urandom_range(tpp / 2));
            else
                send_command(CMD_RELEASE, pick_page(), 1'($urandom_range(1)),
                             $urandom_range(16'hffff));
        end
    endtask

    task automatic test_big_tokens();
        // large token counts with a huge page size
        write_tokens_per_page(16'hffff);
        send_command(CMD_APPEND, 0, 1'b1, 16'hffff);
        send_command(CMD_ROLLBACK, 0, 1'b0, 16'hffff);
        send_command(CMD_ROLLBACK, 0, 1'b0, 0);
        test_random(250);
        write_tokens_per_page(0);
        send_command(CMD_APPEND, 0, 1'b1, 1);
        test_random(60);
        write_tokens_per_page(1);
        test_random(250);
    endtask

    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d page=%0d", $time,
                             status, result_page);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 48'(want.status), 48'(status));
                    check_field("result_page", 48'(want.result_page), 48'(result_page));
                    check_field("page_fill", 48'(want.page_fill), 48'(page_fill));
                    check_field("free_page_count", 48'(want.free_page_count),
                                48'(free_page_count));
                    check_field("free_slot_count", 48'(want.free_slot_count),
                                48'(free_slot_count));
                    check_field("shared_slot_count", 48'(want.shared_slot_count),
                                48'(shared_slot_count));
                    check_field("token_total", want.token_total, token_total);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        failed = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 38;
        recv_idle_pct = 80;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = '0;
        page_id = '0;
        new_page = 1'b0;
        tok_in = '0;
        out_ready = 1'b0;
        for (int i = 0; i < NPG; i++)
        begin
            pg_live[i] = 0;
            pg_slot[i] = 0;
            sl_live[i] = 0;
            sl_fill[i] = 0;
            sl_refs[i] = 0;
        end
        pages_avail = NPG;
        free_slots = NPG;
        shared_cnt = 0;
        tok_total = '0;
        tpp = 16;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_exhaustion();
        test_random(350);
        send_idle_pct = 80;
        recv_idle_pct = 38;
        test_big_tokens();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tokens_per_page(16);
        test_random(400);
        wait_drained();
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
